[sv/fre_pkg.sv]
// Shared types, codes and default sizes for the fragment reassembly engine.
// Used by the top, the front and the back; depends on nothing.
package fre_pkg;

  localparam int SLOTS_DEF        = 4;
  localparam int FRAG_PAYLOAD_DEF = 251;
  localparam int BUFFER_BYTES_DEF = 2048;
  localparam int MAX_FRAGS_DEF    = 8;
  localparam int QUEUE_DEPTH      = 4;
  localparam int ADDR_W           = 16;
  localparam logic [15:0] TIMEOUT_RESET = 16'd5000;

  localparam logic [1:0] FUNC_FRAG = 2'd0;
  localparam logic [1:0] FUNC_TICK = 2'd1;
  localparam logic [1:0] FUNC_READ = 2'd2;

  localparam logic [1:0] KIND_PASS  = 2'd0;
  localparam logic [1:0] KIND_READY = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;
  localparam logic [1:0] KIND_DROP  = 2'd3;

  typedef enum logic [1:0] {
    MODE_HEADER  = 2'd0,
    MODE_PASS    = 2'd1,
    MODE_COLLECT = 2'd2,
    MODE_DISCARD = 2'd3
  } mode_t;

  typedef struct packed {
    logic [1:0]  func;
    logic [7:0]  data_byte;
    logic        last_byte;
    logic [31:0] now_ms;
    logic [1:0]  read_slot;
    logic [10:0] read_offset;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  out_byte;
    logic        end_of_packet;
    logic [1:0]  slot;
    logic [11:0] length;
  } out_item_t;

  typedef struct packed {
    logic              wr_en;
    logic              rd_en;
    logic              res_en;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
    out_item_t         res;
  } cmd_t;

endpackage

[sv/fragment_reassembly_engine.sv]
// An item is accepted in every cycle that push is high and full is low; throughput is one item
// per cycle while full stays low. The front updates the slot table in the accept cycle, the
// command queue registers the command, the back accesses the store when it takes the command,
// which it does only while the result queue has room, and the result queue registers the item.
// Reset clears control state; the slot store is not cleared and holds undefined bytes until written.
module fragment_reassembly_engine #(
  parameter int SLOTS        = fre_pkg::SLOTS_DEF,
  parameter int FRAG_PAYLOAD = fre_pkg::FRAG_PAYLOAD_DEF,
  parameter int BUFFER_BYTES = fre_pkg::BUFFER_BYTES_DEF,
  parameter int MAX_FRAGS    = fre_pkg::MAX_FRAGS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [15:0]        cfg_wdata,
  input  logic               push,
  output logic               full,
  input  fre_pkg::in_item_t  item,
  output logic               empty,
  input  logic               pop,
  output fre_pkg::out_item_t result
);
  localparam int CMD_W = $bits(fre_pkg::cmd_t);
  localparam int RES_W = $bits(fre_pkg::out_item_t);
  localparam int CW    = $clog2(fre_pkg::QUEUE_DEPTH + 1);

  logic               accept;
  logic               cmd_push;
  fre_pkg::cmd_t      cmd_in;
  fre_pkg::cmd_t      cmd_out;
  logic [CMD_W-1:0]   cmd_out_bits;
  logic               cmd_empty;
  logic               cmd_pop;
  logic [CW-1:0]      cmd_count;
  logic               res_push;
  fre_pkg::out_item_t res_in;
  logic [RES_W-1:0]   res_out_bits;
  logic               res_full;
  logic [CW-1:0]      res_count;

  assign accept  = push && !full;
  assign cmd_out = fre_pkg::cmd_t'(cmd_out_bits);
  assign result  = fre_pkg::out_item_t'(res_out_bits);

  fre_front #(
    .SLOTS(SLOTS), .FRAG_PAYLOAD(FRAG_PAYLOAD),
    .BUFFER_BYTES(BUFFER_BYTES), .MAX_FRAGS(MAX_FRAGS)
  ) u_front (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .accept(accept), .item(item), .cmd_push(cmd_push), .cmd(cmd_in)
  );

  fre_fifo #(.WIDTH(CMD_W), .DEPTH(fre_pkg::QUEUE_DEPTH)) u_cmd_q (
    .clk(clk), .rst(rst), .push(cmd_push), .din(cmd_in), .full(full),
    .pop(cmd_pop), .dout(cmd_out_bits), .empty(cmd_empty), .count(cmd_count)
  );

  fre_back #(.SLOTS(SLOTS), .BUFFER_BYTES(BUFFER_BYTES)) u_back (
    .clk(clk), .rst(rst), .cmd_empty(cmd_empty), .cmd(cmd_out), .cmd_pop(cmd_pop),
    .res_count(res_count), .res_full(res_full), .res_push(res_push), .res(res_in)
  );

  fre_fifo #(.WIDTH(RES_W), .DEPTH(fre_pkg::QUEUE_DEPTH)) u_res_q (
    .clk(clk), .rst(rst), .push(res_push), .din(res_in), .full(res_full),
    .pop(pop), .dout(res_out_bits), .empty(empty), .count(res_count)
  );

  a_full_matches_count: assert property (@(posedge clk) disable iff (rst)
    full |-> cmd_count == CW'(fre_pkg::QUEUE_DEPTH))
    else $error("Full raised while the command queue has room.");

endmodule

[sv/fre_fifo.sv]
// Small register queue used between the front, the back and the result port.
// Depends on nothing; DEPTH must be a power of two.
module fre_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  logic [WIDTH-1:0]           din,
  output logic                       full,
  input  logic                       pop,
  output logic [WIDTH-1:0]           dout,
  output logic                       empty,
  output logic [$clog2(DEPTH+1)-1:0] count
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH+1);

  logic [WIDTH-1:0] entries [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + PW'(1);
      if (do_pop) rd_ptr <= rd_ptr + PW'(1);
      if (do_push && !do_pop) count <= count + CW'(1);
      else if (do_pop && !do_push) count <= count - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) entries[wr_ptr] <= din;
  end

endmodule

[sv/fre_front.sv]
// Front part: parses fragment headers, keeps the slot table and aging, and issues commands.
// Depends on fre_pkg.
module fre_front #(
  parameter int SLOTS        = fre_pkg::SLOTS_DEF,
  parameter int FRAG_PAYLOAD = fre_pkg::FRAG_PAYLOAD_DEF,
  parameter int BUFFER_BYTES = fre_pkg::BUFFER_BYTES_DEF,
  parameter int MAX_FRAGS    = fre_pkg::MAX_FRAGS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [15:0]      cfg_wdata,
  input  logic             accept,
  input  fre_pkg::in_item_t item,
  output logic             cmd_push,
  output fre_pkg::cmd_t    cmd
);
  localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int LW = $clog2(BUFFER_BYTES + 1);

  logic [15:0]          timeout;
  logic [SLOTS-1:0]     slot_active, slot_active_next;
  logic [SLOTS-1:0]     slot_ready, slot_ready_next;
  logic [15:0]          slot_id [SLOTS];
  logic [15:0]          slot_id_next [SLOTS];
  logic [31:0]          slot_start [SLOTS];
  logic [31:0]          slot_start_next [SLOTS];
  logic [MAX_FRAGS-1:0] slot_mask [SLOTS];
  logic [MAX_FRAGS-1:0] slot_mask_next [SLOTS];
  logic [LW-1:0]        slot_fill [SLOTS];
  logic [LW-1:0]        slot_fill_next [SLOTS];
  logic [7:0]           byte_position, byte_position_next;
  logic [15:0]          current_id, current_id_next;
  logic [7:0]           current_index, current_index_next;
  logic [7:0]           current_total, current_total_next;
  logic [SW-1:0]        current_slot, current_slot_next;
  logic [15:0]          frag_base, frag_base_next;
  fre_pkg::mode_t       mode, mode_next;

  function automatic logic [LW-1:0] raise(input logic [LW-1:0] f, input logic [16:0] e);
    logic [16:0] c;
    c = (e > 17'(BUFFER_BYTES)) ? 17'(BUFFER_BYTES) : e;
    return (c > 17'(f)) ? LW'(c) : f;
  endfunction

  always_comb begin
    logic [7:0]           pos;
    logic                 found;
    logic                 alloc;
    logic [SW-1:0]        fs;
    logic                 do_finish;
    logic [16:0]          off;
    logic [MAX_FRAGS-1:0] need;
    logic [MAX_FRAGS-1:0] m;

    slot_active_next   = slot_active;
    slot_ready_next    = slot_ready;
    slot_id_next       = slot_id;
    slot_start_next    = slot_start;
    slot_mask_next     = slot_mask;
    slot_fill_next     = slot_fill;
    byte_position_next = byte_position;
    current_id_next    = current_id;
    current_index_next = current_index;
    current_total_next = current_total;
    current_slot_next  = current_slot;
    frag_base_next     = frag_base;
    mode_next          = mode;
    cmd                = '0;
    cmd_push           = 1'b0;
    pos                = byte_position;
    found              = 1'b0;
    alloc              = 1'b0;
    fs                 = '0;
    do_finish          = 1'b0;
    off                = '0;
    need               = '0;
    m                  = '0;

    if (accept) begin
      case (item.func)
        fre_pkg::FUNC_FRAG: begin
          if (byte_position != 8'hFF) byte_position_next = byte_position + 8'd1;
          case (mode)
            fre_pkg::MODE_HEADER: begin
              if (pos == 8'd0) current_id_next = {item.data_byte, current_id[7:0]};
              else if (pos == 8'd1) current_id_next = {current_id[15:8], item.data_byte};
              else if (pos == 8'd2) current_index_next = item.data_byte;
              else current_total_next = item.data_byte;
              if (pos < 8'd3) begin
                if (item.last_byte) begin
                  cmd.res_en    = 1'b1;
                  cmd.res.kind  = fre_pkg::KIND_DROP;
                end
              end else if (current_total_next == 8'd0 ||
                           current_index_next >= current_total_next) begin
                mode_next    = fre_pkg::MODE_DISCARD;
                cmd.res_en   = 1'b1;
                cmd.res.kind = fre_pkg::KIND_DROP;
              end else if (current_total_next == 8'd1) begin
                mode_next = fre_pkg::MODE_PASS;
              end else begin
                for (int i = 0; i < SLOTS; i++) begin
                  if (!found && slot_active[i] && slot_id[i] == current_id_next) begin
                    found = 1'b1;
                    fs    = SW'(i);
                  end
                end
                for (int i = 0; i < SLOTS; i++) begin
                  if (!found && !slot_active[i] && !slot_ready[i]) begin
                    found = 1'b1;
                    alloc = 1'b1;
                    fs    = SW'(i);
                  end
                end
                if (!found) begin
                  mode_next    = fre_pkg::MODE_DISCARD;
                  cmd.res_en   = 1'b1;
                  cmd.res.kind = fre_pkg::KIND_DROP;
                end else begin
                  current_slot_next = fs;
                  mode_next         = fre_pkg::MODE_COLLECT;
                  frag_base_next    = 16'(current_index_next) * 16'(FRAG_PAYLOAD);
                  for (int i = 0; i < SLOTS; i++) begin
                    if (SW'(i) == fs) begin
                      if (alloc) begin
                        slot_active_next[i] = 1'b1;
                        slot_id_next[i]     = current_id_next;
                        slot_start_next[i]  = item.now_ms;
                        slot_mask_next[i]   = '0;
                        slot_fill_next[i]   = '0;
                      end
                      slot_fill_next[i] = raise(slot_fill_next[i], 17'(frag_base_next));
                    end
                  end
                  do_finish = item.last_byte;
                end
              end
            end
            fre_pkg::MODE_PASS: begin
              cmd.res_en            = 1'b1;
              cmd.res.kind          = fre_pkg::KIND_PASS;
              cmd.res.out_byte      = item.data_byte;
              cmd.res.end_of_packet = item.last_byte;
            end
            fre_pkg::MODE_COLLECT: begin
              if (pos != 8'hFF) begin
                off = 17'(frag_base) + 17'(pos) - 17'd4;
                if (off < 17'(BUFFER_BYTES)) begin
                  cmd.wr_en = 1'b1;
                  cmd.addr  = fre_pkg::ADDR_W'(17'(current_slot) * 17'(BUFFER_BYTES) + off);
                  cmd.data  = item.data_byte;
                end
                for (int i = 0; i < SLOTS; i++) begin
                  if (SW'(i) == current_slot) begin
                    slot_fill_next[i] = raise(slot_fill[i], off + 17'd1);
                  end
                end
              end
              do_finish = item.last_byte;
            end
            default: begin
            end
          endcase
          if (do_finish) begin
            for (int i = 0; i < SLOTS; i++) begin
              if (SW'(i) == current_slot_next) begin
                m = slot_mask_next[i] | (MAX_FRAGS'(1) << current_index_next);
                slot_mask_next[i] = m;
                need = (current_total_next < 8'(MAX_FRAGS)) ?
                       ((MAX_FRAGS'(1) << current_total_next) - MAX_FRAGS'(1)) : '1;
                if ((m & need) == need) begin
                  slot_active_next[i] = 1'b0;
                  slot_ready_next[i]  = 1'b1;
                  cmd.res_en          = 1'b1;
                  cmd.res.kind        = fre_pkg::KIND_READY;
                  cmd.res.slot        = 2'(current_slot_next);
                  cmd.res.length      = 12'(slot_fill_next[i]);
                end
              end
            end
          end
          if (item.last_byte) begin
            byte_position_next = '0;
            mode_next          = fre_pkg::MODE_HEADER;
          end
        end
        fre_pkg::FUNC_TICK: begin
          for (int i = 0; i < SLOTS; i++) begin
            if (slot_active[i] && (item.now_ms - slot_start[i]) > {16'd0, timeout}) begin
              slot_active_next[i] = 1'b0;
              slot_mask_next[i]   = '0;
              slot_fill_next[i]   = '0;
              if (mode == fre_pkg::MODE_COLLECT && current_slot == SW'(i)) begin
                mode_next = fre_pkg::MODE_DISCARD;
              end
            end
          end
        end
        fre_pkg::FUNC_READ: begin
          cmd.res_en   = 1'b1;
          cmd.res.kind = fre_pkg::KIND_READ;
          if (int'(item.read_slot) < SLOTS && int'(item.read_offset) < BUFFER_BYTES) begin
            cmd.rd_en = 1'b1;
            cmd.addr  = fre_pkg::ADDR_W'(17'(item.read_slot) * 17'(BUFFER_BYTES) +
                                         17'(item.read_offset));
            for (int i = 0; i < SLOTS; i++) begin
              if (2'(i) == item.read_slot && item.last_byte && slot_ready[i]) begin
                slot_ready_next[i] = 1'b0;
                slot_mask_next[i]  = '0;
                slot_fill_next[i]  = '0;
              end
            end
          end
        end
        default: begin
        end
      endcase
      cmd_push = cmd.wr_en || cmd.rd_en || cmd.res_en;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout       <= fre_pkg::TIMEOUT_RESET;
      slot_active   <= '0;
      slot_ready    <= '0;
      byte_position <= '0;
      current_id    <= '0;
      current_index <= '0;
      current_total <= '0;
      current_slot  <= '0;
      frag_base     <= '0;
      mode          <= fre_pkg::MODE_HEADER;
      for (int i = 0; i < SLOTS; i++) begin
        slot_id[i]    <= '0;
        slot_start[i] <= '0;
        slot_mask[i]  <= '0;
        slot_fill[i]  <= '0;
      end
    end else begin
      if (cfg_we) timeout <= cfg_wdata;
      slot_active   <= slot_active_next;
      slot_ready    <= slot_ready_next;
      byte_position <= byte_position_next;
      current_id    <= current_id_next;
      current_index <= current_index_next;
      current_total <= current_total_next;
      current_slot  <= current_slot_next;
      frag_base     <= frag_base_next;
      mode          <= mode_next;
      slot_id       <= slot_id_next;
      slot_start    <= slot_start_next;
      slot_mask     <= slot_mask_next;
      slot_fill     <= slot_fill_next;
    end
  end

  a_active_ready_disjoint: assert property (@(posedge clk) disable iff (rst)
    (slot_active & slot_ready) == '0)
    else $error("A slot is both collecting and ready.");

  a_write_in_collect: assert property (@(posedge clk) disable iff (rst)
    cmd_push && cmd.wr_en |-> mode == fre_pkg::MODE_COLLECT)
    else $error("A store write was issued outside collection.");

endmodule

[sv/fre_back.sv]
// Back part: executes commands against the slot store and forms result items.
// Depends on fre_pkg.
module fre_back #(
  parameter int SLOTS        = fre_pkg::SLOTS_DEF,
  parameter int BUFFER_BYTES = fre_pkg::BUFFER_BYTES_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    cmd_empty,
  input  fre_pkg::cmd_t                           cmd,
  output logic                                    cmd_pop,
  input  logic [$clog2(fre_pkg::QUEUE_DEPTH+1)-1:0] res_count,
  input  logic                                    res_full,
  output logic                                    res_push,
  output fre_pkg::out_item_t                      res
);
  localparam int DEPTH = SLOTS * BUFFER_BYTES;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(fre_pkg::QUEUE_DEPTH + 1);

  logic [7:0]         store [DEPTH];
  logic [7:0]         rdata;
  logic               s1_valid;
  logic               s1_from_mem;
  fre_pkg::out_item_t s1_res;

  assign cmd_pop = !cmd_empty &&
                   (32'(res_count) + 32'(s1_valid) < fre_pkg::QUEUE_DEPTH);

  always_ff @(posedge clk) begin
    if (cmd_pop && cmd.wr_en) store[cmd.addr[AW-1:0]] <= cmd.data;
    if (cmd_pop && cmd.rd_en) rdata <= store[cmd.addr[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= cmd_pop && cmd.res_en;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      s1_res      <= cmd.res;
      s1_from_mem <= cmd.rd_en;
    end
  end

  always_comb begin
    res_push = s1_valid;
    res      = s1_res;
    if (s1_from_mem) res.out_byte = rdata;
  end

  a_no_result_overflow: assert property (@(posedge clk) disable iff (rst)
    s1_valid |-> !res_full)
    else $error("Result queue overflow.");

  a_room_reserved: assert property (@(posedge clk) disable iff (rst)
    cmd_pop |-> res_count != CW'(fre_pkg::QUEUE_DEPTH))
    else $error("Command taken without room for its result.");

endmodule
